// ===== sv/fsf_pkg.sv =====
// ---------------------------------------------------------------------------
// fsf_pkg: shared types, constants and helpers of the FASTA sequence filter
// Holds the character codes, the queue entry format that passes between the
// front and back parts, and the saturating count increment.
// ---------------------------------------------------------------------------
package fsf_pkg;

  // Character codes.
  localparam logic [7:0] CHR_GT = 8'h3E;  // '>'
  localparam logic [7:0] CHR_NL = 8'h0A;  // newline
  localparam logic [7:0] CHR_A  = 8'h41;
  localparam logic [7:0] CHR_C  = 8'h43;
  localparam logic [7:0] CHR_G  = 8'h47;
  localparam logic [7:0] CHR_T  = 8'h54;
  localparam logic [7:0] CHR_U  = 8'h55;
  localparam logic [7:0] CHR_N  = 8'h4E;
  localparam logic [7:0] CHR_LA = 8'h61;  // 'a'
  localparam logic [7:0] CHR_LZ = 8'h7A;  // 'z'
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  localparam int unsigned COUNT_W = 32;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Default number of entries in the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;

  // One queued work unit. It yields one result, or two when dbl is set, in
  // which case the second result is a newline that closes the text.
  typedef struct packed {
    logic [7:0]         ch0;   // first emitted byte
    logic [COUNT_W-1:0] cnt0;  // running count carried by the first byte
    logic               dbl;   // a closing newline follows the first byte
    logic               fin;   // input byte was the last of the text
  } fsf_entry_t;

  // Saturating increment of the emitted byte count.
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + {{(COUNT_W-1){1'b0}}, 1'b1};
  endfunction

endpackage

// ===== sv/fsf_front.sv =====
// ---------------------------------------------------------------------------
// fsf_front: input classification of the FASTA sequence filter
// Accepts one byte per cycle while the queue has space, tracks header and
// record state and the running count, and pushes an entry per emitting byte.
// ---------------------------------------------------------------------------
module fsf_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_char,
  input  logic                   in_final_byte,
  input  logic                   q_space,
  output logic                   q_push,
  output fsf_pkg::fsf_entry_t    q_entry
);
  import fsf_pkg::*;

  logic               hdr_r, hdr_nxt;
  logic               rec_r, rec_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;

  logic       is_gt;
  logic [7:0] up_char;
  logic       is_nuc;
  logic       emit_nl_gt;
  logic       emit_nuc;
  logic       rec_after;
  logic       emit_nl_end;
  logic       any_emit;
  logic       acc;
  logic [COUNT_W-1:0] cnt0;

  assign in_ready = q_space;
  assign acc      = in_valid && in_ready;

  // Classify the byte: header start, upper-cased letter, nucleotide test.
  always_comb begin
    is_gt   = (in_char == CHR_GT);
    up_char = (in_char >= CHR_LA && in_char <= CHR_LZ) ? in_char - CASE_OFFSET : in_char;
    is_nuc  = up_char inside {CHR_A, CHR_C, CHR_G, CHR_T, CHR_U, CHR_N};
  end

  // Decide which bytes go out and what the state becomes.
  always_comb begin
    emit_nl_gt  = is_gt && rec_r;
    emit_nuc    = !is_gt && !hdr_r && is_nuc;
    rec_after   = is_gt ? 1'b0 : (emit_nuc ? 1'b1 : rec_r);
    emit_nl_end = in_final_byte && rec_after;
    any_emit    = emit_nl_gt || emit_nuc || emit_nl_end;
    cnt0        = sat_inc(total_r);

    if (is_gt) begin
      hdr_nxt = 1'b1;
    end else if (hdr_r && in_char == CHR_NL) begin
      hdr_nxt = 1'b0;
    end else begin
      hdr_nxt = hdr_r;
    end
    rec_nxt   = rec_after;
    // Two results only happen on the final byte, so one increment suffices.
    total_nxt = any_emit ? cnt0 : total_r;
    if (in_final_byte) begin
      hdr_nxt   = 1'b0;
      rec_nxt   = 1'b0;
      total_nxt = '0;
    end

    q_push        = acc && any_emit;
    q_entry.ch0   = emit_nuc ? up_char : CHR_NL;
    q_entry.cnt0  = cnt0;
    q_entry.dbl   = emit_nuc && in_final_byte;
    q_entry.fin   = in_final_byte;
  end

  // State registers, updated on every transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r   <= 1'b0;
      rec_r   <= 1'b0;
      total_r <= '0;
    end else if (acc) begin
      hdr_r   <= hdr_nxt;
      rec_r   <= rec_nxt;
      total_r <= total_nxt;
    end
  end

endmodule

// ===== sv/fsf_queue.sv =====
// ---------------------------------------------------------------------------
// fsf_queue: entry queue between the front and back parts
// A small circular buffer of work entries with a registered fill count.
// ---------------------------------------------------------------------------
module fsf_queue #(
  parameter int unsigned DEPTH = fsf_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fsf_pkg::fsf_entry_t push_entry,
  output logic                space,
  input  logic                pop,
  output logic                head_valid,
  output fsf_pkg::fsf_entry_t head_entry
);
  import fsf_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fsf_entry_t       slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign space      = (count_r != CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slots_r[rd_ptr_r];

  // Pointer wrap and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  // Never written when full, never read when empty.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> space)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue pop while empty");

endmodule

// ===== sv/fsf_back.sv =====
// ---------------------------------------------------------------------------
// fsf_back: result emission of the FASTA sequence filter
// Takes queue entries and drives the output register, splitting an entry
// with a closing newline into two transfers.
// ---------------------------------------------------------------------------
module fsf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  fsf_pkg::fsf_entry_t head_entry,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_char,
  output logic                out_run_last,
  output logic                out_stream_done,
  output logic [31:0]         out_emitted_count
);
  import fsf_pkg::*;

  logic               phase_r, phase_nxt;  // first half of a double entry sent
  logic               oval_r, oval_nxt;
  logic [7:0]         ochar_r, ochar_nxt;
  logic               olast_r, olast_nxt;
  logic               odone_r, odone_nxt;
  logic [COUNT_W-1:0] ocnt_r, ocnt_nxt;
  logic               load;

  assign load = !oval_r || out_ready;

  // Next output transfer and queue pop.
  always_comb begin
    phase_nxt = phase_r;
    oval_nxt  = oval_r;
    ochar_nxt = ochar_r;
    olast_nxt = olast_r;
    odone_nxt = odone_r;
    ocnt_nxt  = ocnt_r;
    pop       = 1'b0;
    if (load) begin
      oval_nxt = head_valid;
      if (head_valid) begin
        if (phase_r) begin
          // Closing newline after the last nucleotide.
          ochar_nxt = CHR_NL;
          ocnt_nxt  = sat_inc(head_entry.cnt0);
          olast_nxt = 1'b1;
          odone_nxt = head_entry.fin;
          phase_nxt = 1'b0;
          pop       = 1'b1;
        end else begin
          ochar_nxt = head_entry.ch0;
          ocnt_nxt  = head_entry.cnt0;
          olast_nxt = !head_entry.dbl;
          odone_nxt = head_entry.fin && !head_entry.dbl;
          phase_nxt = head_entry.dbl;
          pop       = !head_entry.dbl;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
    ocnt_r  <= ocnt_nxt;
  end

  assign out_valid         = oval_r;
  assign out_char          = ochar_r;
  assign out_run_last      = olast_r;
  assign out_stream_done   = odone_r;
  assign out_emitted_count = ocnt_r;

  // A split entry stays at the queue head until its newline is sent.
  a_phase_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> head_valid)
    else $error("split entry lost from queue head");
  // A result that is not the last of its byte is always the first half.
  a_partial_is_first: assert property (@(posedge clk) disable iff (!rst_n)
    (oval_r && !olast_r) |-> phase_r)
    else $error("non-final result without pending newline");
  // The end-of-text mark only sits on a byte's last result.
  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (oval_r && odone_r) |-> olast_r)
    else $error("stream_done without run_last");

endmodule

// ===== sv/fasta_sequence_filter_unit.sv =====
// ---------------------------------------------------------------------------
// fasta_sequence_filter_unit: FASTA sequences, one byte per cycle if unstalled
// The block takes one byte of FASTA text per transfer and returns the
// sequence letters, upper-cased, one record per line, with a running count.
// It accepts a new byte every cycle while the queue has space. Each byte
// yields zero, one or two results; the only two-result case is a nucleotide
// on the last byte of the text, which takes two output transfers. The front
// part classifies combinationally, a queue of QDEPTH entries absorbs output
// stalls, and each result passes through the queue storage and the output
// register. The single output register bounds the rate at one result per
// cycle while out_ready is high.
// ---------------------------------------------------------------------------
module fasta_sequence_filter_unit #(
  parameter int unsigned QDEPTH = fsf_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        out_run_last,
  output logic        out_stream_done,
  output logic [31:0] out_emitted_count
);
  import fsf_pkg::*;

  logic       q_space;
  logic       q_push;
  logic       q_pop;
  logic       q_valid;
  fsf_entry_t q_in;
  fsf_entry_t q_head;

  // Classification and state.
  fsf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_char       (in_char),
    .in_final_byte (in_final_byte),
    .q_space       (q_space),
    .q_push        (q_push),
    .q_entry       (q_in)
  );

  // Decoupling queue.
  fsf_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .space      (q_space),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head)
  );

  // Result emission.
  fsf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (q_valid),
    .head_entry        (q_head),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_char          (out_char),
    .out_run_last      (out_run_last),
    .out_stream_done   (out_stream_done),
    .out_emitted_count (out_emitted_count)
  );

endmodule

// ===== dv/fasta_sequence_filter_checker.sv =====
// ---------------------------------------------------------------------------
// fasta_sequence_filter_checker: result predictor and scoreboard
// Watches the byte input and the result output of the FASTA sequence filter.
// Each input transfer is run through a local model of the filter, and the
// results it implies are queued. Each output transfer is compared field by
// field against the oldest queued result.
// ---------------------------------------------------------------------------
module fasta_sequence_filter_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_char,
  input  logic        in_final_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_char,
  input  logic        out_run_last,
  input  logic        out_stream_done,
  input  logic [31:0] out_emitted_count,
  output int unsigned fail_count,
  output int unsigned outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import fsf_pkg::*;

  localparam int unsigned MAX_REPORTS = 10;

  // One predicted output byte with its flags and running count.
  typedef struct {
    logic [7:0]  ch;
    logic        run_last;
    logic        stream_done;
    logic [31:0] count;
  } emit_t;

  emit_t expected_emits[$];

  // Local copy of the filter state.
  logic        header_on;
  logic        record_open;
  logic [31:0] emit_total;

  // Count a failure and describe it while the report budget lasts.
  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  // Produce one output byte and advance the saturating count.
  function automatic emit_t make_emit(input logic [7:0] ch);
    emit_t e;
    if (emit_total != '1) begin
      emit_total = emit_total + 32'd1;
    end
    e.ch = ch;
    e.run_last = 1'b0;
    e.stream_done = 1'b0;
    e.count = emit_total;
    return e;
  endfunction

  // Apply one input byte to the local state and queue the results it causes.
  function automatic void filter_byte(input logic [7:0] ch, input logic fin);
    logic [7:0] up;
    emit_t      burst[$];
    emit_t      e;
    up = (ch >= CHR_LA && ch <= CHR_LZ) ? ch - CASE_OFFSET : ch;
    if (ch == CHR_GT) begin
      // A header start closes an open record with a newline.
      if (record_open) begin
        burst.push_back(make_emit(CHR_NL));
        record_open = 1'b0;
      end
      header_on = 1'b1;
    end else if (header_on) begin
      if (ch == CHR_NL) begin
        header_on = 1'b0;
      end
    end else if (up == CHR_A || up == CHR_C || up == CHR_G || up == CHR_T ||
                 up == CHR_U || up == CHR_N) begin
      burst.push_back(make_emit(up));
      record_open = 1'b1;
    end

    // The last byte of a text closes any open record.
    if (fin && record_open) begin
      burst.push_back(make_emit(CHR_NL));
    end

    if (burst.size() > 0) begin
      e = burst.pop_back();
      e.run_last = 1'b1;
      e.stream_done = fin;
      burst.push_back(e);
    end
    foreach (burst[i]) begin
      expected_emits.push_back(burst[i]);
    end

    // A new text starts from a clean state.
    if (fin) begin
      header_on = 1'b0;
      record_open = 1'b0;
      emit_total = '0;
    end
  endfunction

  // Compare output transfers, then predict from input transfers.
  always @(posedge clk) begin : monitor
    emit_t want;
    if (!rst_n) begin
      header_on = 1'b0;
      record_open = 1'b0;
      emit_total = '0;
      expected_emits.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_emits.size() == 0) begin
          note_failure($sformatf("unexpected result: char %02h last %0b done %0b count %0d",
                                 out_char, out_run_last, out_stream_done,
                                 out_emitted_count));
        end else begin
          want = expected_emits.pop_front();
          if (out_char !== want.ch || out_run_last !== want.run_last ||
              out_stream_done !== want.stream_done || out_emitted_count !== want.count) begin
            note_failure($sformatf(
                {"result differs: expected char %02h last %0b done %0b count %0d,",
                 " got char %02h last %0b done %0b count %0d"},
                want.ch, want.run_last, want.stream_done, want.count,
                out_char, out_run_last, out_stream_done, out_emitted_count));
          end
        end
      end
      if (in_valid && in_ready) begin
        filter_byte(in_char, in_final_byte);
      end
    end
    outstanding <= expected_emits.size();
  end

endmodule

// ===== dv/fasta_sequence_filter_unit_tb.sv =====
// ---------------------------------------------------------------------------
// fasta_sequence_filter_unit_tb: top level testbench of the FASTA filter
// Feeds directed bytes and then random FASTA texts and noise through the
// filter with random idle and stall bursts, one long output stall, and a
// final stretch without gaps. A checker beside the block predicts and
// compares every result; this module only drives stimulus and reports.
// ---------------------------------------------------------------------------
module fasta_sequence_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fsf_pkg::*;

  localparam int unsigned ITEM_TARGET  = 1925;
  localparam int unsigned QUIET_ITEMS  = 250;
  localparam int unsigned LONG_HOLD    = 64;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_char;
  logic        in_final_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_char;
  logic        out_run_last;
  logic        out_stream_done;
  logic [31:0] out_emitted_count;

  int unsigned fail_count;
  int unsigned outstanding;

  // Stimulus state of the source; the sink also reads quiet and hold_request.
  // Only the source writes these; the sink keeps its own record of having held off.
  int unsigned bytes_sent = 0;
  bit          src_idle_on = 1'b1;
  bit          quiet = 1'b0;
  bit          hold_request = 1'b0;
  logic [7:0]  text_q[$];

  always #1 clk = ~clk;

  fasta_sequence_filter_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char           (in_char),
    .in_final_byte     (in_final_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_char          (out_char),
    .out_run_last      (out_run_last),
    .out_stream_done   (out_stream_done),
    .out_emitted_count (out_emitted_count)
  );

  fasta_sequence_filter_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char           (in_char),
    .in_final_byte     (in_final_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_char          (out_char),
    .out_run_last      (out_run_last),
    .out_stream_done   (out_stream_done),
    .out_emitted_count (out_emitted_count),
    .fail_count        (fail_count),
    .outstanding       (outstanding)
  );

  // Offer one byte, with an optional idle burst first, and wait for the transfer.
  task automatic send_byte(input logic [7:0] ch, input logic fin);
    if (src_idle_on && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char <= ch;
    in_final_byte <= fin;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // A sequence byte: mostly a nucleotide in either case, sometimes any byte.
  function automatic logic [7:0] seq_byte();
    logic [7:0] letters[6] = '{CHR_A, CHR_C, CHR_G, CHR_T, CHR_U, CHR_N};
    logic [7:0] b;
    if ($urandom_range(0, 99) < 88) begin
      b = letters[$urandom_range(0, 5)];
      if ($urandom_range(0, 1) == 1) begin
        b = b + CASE_OFFSET;
      end
    end else begin
      b = 8'($urandom_range(0, 255));
    end
    return b;
  endfunction

  task automatic add_seq_line();
    int unsigned len;
    len = $urandom_range(1, 10);
    repeat (len) text_q.push_back(seq_byte());
    text_q.push_back(CHR_NL);
  endtask

  // Well-formed FASTA text with random headers, lines and endings.
  task automatic build_fasta_text();
    int unsigned n_rec;
    int unsigned hdr_len;
    logic [7:0]  b;
    text_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      add_seq_line();
    end
    n_rec = $urandom_range(1, 3);
    repeat (n_rec) begin
      text_q.push_back(CHR_GT);
      hdr_len = $urandom_range(0, 6);
      repeat (hdr_len) begin
        do b = 8'($urandom_range(0, 255)); while (b == CHR_NL);
        if ($urandom_range(0, 7) == 0) begin
          b = CHR_GT;
        end
        text_q.push_back(b);
      end
      text_q.push_back(CHR_NL);
      repeat ($urandom_range(0, 3)) add_seq_line();
    end
    // End on a newline, a bare letter, a header start or whatever came last.
    if ($urandom_range(0, 3) == 0 && text_q.size() > 1) begin
      void'(text_q.pop_back());
    end else if ($urandom_range(0, 2) == 0) begin
      text_q.push_back(seq_byte());
    end else if ($urandom_range(0, 4) == 0) begin
      text_q.push_back(CHR_GT);
    end
  endtask

  // Short run of arbitrary bytes.
  task automatic build_noise();
    text_q.delete();
    repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Send the prepared text, marking its last byte.
  task automatic send_text();
    foreach (text_q[i]) begin
      send_byte(text_q[i], i == text_q.size() - 1);
    end
  endtask

  // Directed bytes: every nucleotide letter, dropped bytes, header corner
  // cases, and each way a text can end.
  task automatic run_directed();
    send_byte(CHR_A, 1'b0);
    send_byte("c", 1'b0);
    send_byte("g", 1'b0);
    send_byte("t", 1'b0);
    send_byte("u", 1'b0);
    send_byte("n", 1'b0);
    send_byte("z", 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CHR_NL, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte("B", 1'b0);
    // Header start with a record open, then a second header start inside it.
    send_byte(CHR_GT, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CHR_GT, 1'b0);
    send_byte(CHR_A, 1'b0);
    send_byte(CHR_NL, 1'b0);
    send_byte(CHR_G, 1'b0);
    // Text ends on a header start that closes the record.
    send_byte(CHR_GT, 1'b1);
    // Letter on the last byte gives two results.
    send_byte(CHR_T, 1'b1);
    // Last bytes that cause no result at all.
    send_byte("Q", 1'b1);
    send_byte(CHR_GT, 1'b0);
    send_byte(CHR_NL, 1'b1);
    // Dropped last byte that still closes an open record.
    send_byte("a", 1'b0);
    send_byte("x", 1'b1);
  endtask

  // Output side: random stall bursts, one long hold-off, no stalls at the end.
  initial begin : result_sink
    bit stall_mode;
    bit held;
    stall_mode = 1'b1;
    held = 1'b0;
    out_ready <= 1'b0;
    repeat (10) @(posedge clk);
    forever begin
      if (hold_request && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (stall_mode && !quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      if ($urandom_range(0, 15) == 0) begin
        stall_mode = !stall_mode;
      end
    end
  end

  // Input side and verdict.
  initial begin : stimulus
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_char <= '0;
    in_final_byte <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    while (bytes_sent < ITEM_TARGET) begin
      if (!hold_request && bytes_sent >= ITEM_TARGET / 2) begin
        hold_request = 1'b1;
      end
      if (bytes_sent >= ITEM_TARGET - QUIET_ITEMS) begin
        quiet = 1'b1;
      end
      src_idle_on = !quiet && ($urandom_range(0, 9) < 7);
      if ($urandom_range(0, 99) < 85) begin
        build_fasta_text();
      end else begin
        build_noise();
      end
      send_text();
    end
    in_valid <= 1'b0;

    // Let every expected result arrive, then watch for stray ones.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
